// ----- hw/rtl/gcr_pkg.sv -----
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, constants and font table for the glyph cell rasterizer.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int TOP_MARGIN = 2;
    localparam logic [3:0] ADV_BLANK  = 4'd6;
    localparam logic [3:0] ADV_NORMAL = 4'd11;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_QMARK = 7'h3F;

    typedef logic [4:0] glyph_row_t;
    typedef glyph_row_t [GLYPH_ROWS-1:0] glyph_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [6:0] ch;
        logic [7:0] slot;
    } gcr_item_t;

    function automatic logic [6:0] fold_to_ascii(input logic [20:0] cp);
        logic [6:0] r;
        r = CH_QMARK;
        if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) r = CH_QMARK;
        else if (cp < 21'h80) r = cp[6:0];
        else if ((cp >= 21'hC0 && cp <= 21'hC6) || (cp >= 21'hE0 && cp <= 21'hE6))
            r = 7'h41;
        else if ((cp >= 21'hC8 && cp <= 21'hCB) || (cp >= 21'hE8 && cp <= 21'hEB))
            r = 7'h45;
        else if ((cp >= 21'hCC && cp <= 21'hCF) || (cp >= 21'hEC && cp <= 21'hEF))
            r = 7'h49;
        else if ((cp >= 21'hD2 && cp <= 21'hD6) || (cp >= 21'hF2 && cp <= 21'hF6) ||
                 cp == 21'hD8 || cp == 21'hF8) r = 7'h4F;
        else if ((cp >= 21'hD9 && cp <= 21'hDC) || (cp >= 21'hF9 && cp <= 21'hFC))
            r = 7'h55;
        else begin
            case (cp)
                21'hA0: r = CH_SPACE;
                21'hA1: r = 7'h21;
                21'hA9, 21'hC7, 21'hE7: r = 7'h43;
                21'hAB, 21'hBB, 21'h201C, 21'h201D: r = 7'h22;
                21'hB0: r = 7'h6F;
                21'hB7, 21'h2026: r = 7'h2E;
                21'hD0, 21'hF0: r = 7'h44;
                21'hD1, 21'hF1: r = 7'h4E;
                21'hDD, 21'hFD, 21'hFF: r = 7'h59;
                21'hDE, 21'hFE: r = 7'h50;
                21'hDF: r = 7'h53;
                21'hD7: r = 7'h78;
                21'hF7: r = 7'h2F;
                21'h2013, 21'h2014: r = 7'h2D;
                21'h2018, 21'h2019: r = 7'h27;
                21'h2022: r = 7'h2A;
                21'h20AC: r = 7'h45;
                default: r = CH_QMARK;
            endcase
        end
        return r;
    endfunction

    // Font ROM, rows top first; missing characters give the question mark.
    function automatic glyph_t font_rom(input logic [6:0] ch_in);
        logic [6:0] ch;
        logic [34:0] b;
        ch = (ch_in >= 7'h61 && ch_in <= 7'h7A) ? ch_in - 7'd32 : ch_in;
        case (ch)
            7'h20: b = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
            7'h41: b = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            7'h42: b = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
            7'h43: b = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
            7'h44: b = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
            7'h45: b = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
            7'h46: b = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
            7'h47: b = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E};
            7'h48: b = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            7'h49: b = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
            7'h4A: b = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
            7'h4B: b = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
            7'h4C: b = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
            7'h4D: b = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
            7'h4E: b = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
            7'h4F: b = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            7'h50: b = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
            7'h51: b = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
            7'h52: b = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
            7'h53: b = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
            7'h54: b = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
            7'h55: b = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            7'h56: b = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
            7'h57: b = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
            7'h58: b = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
            7'h59: b = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
            7'h5A: b = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
            7'h30: b = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
            7'h31: b = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
            7'h32: b = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
            7'h33: b = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
            7'h34: b = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
            7'h35: b = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
            7'h36: b = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
            7'h37: b = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
            7'h38: b = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
            7'h39: b = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
            7'h2E: b = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06};
            7'h2C: b = {5'h00,5'h00,5'h00,5'h00,5'h06,5'h06,5'h04};
            7'h3A: b = {5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h00};
            7'h3B: b = {5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h04};
            7'h21: b = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
            7'h2D: b = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
            7'h2B: b = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
            7'h2F: b = {5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00};
            7'h5C: b = {5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00};
            7'h28: b = {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02};
            7'h29: b = {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08};
            7'h5B: b = {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E};
            7'h5D: b = {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E};
            7'h7B: b = {5'h02,5'h04,5'h04,5'h08,5'h04,5'h04,5'h02};
            7'h7D: b = {5'h08,5'h04,5'h04,5'h02,5'h04,5'h04,5'h08};
            7'h5F: b = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F};
            7'h22: b = {5'h0A,5'h0A,5'h04,5'h00,5'h00,5'h00,5'h00};
            7'h27: b = {5'h04,5'h04,5'h02,5'h00,5'h00,5'h00,5'h00};
            default: b = {5'h0E,5'h11,5'h02,5'h04,5'h04,5'h00,5'h04};
        endcase
        return glyph_t'(b);
    endfunction

endpackage

// ----- hw/rtl/gcr_front.sv -----
// ----------------------------------------------------------------------------
// gcr_front
// Accepts codepoints, folds them to ASCII and pushes them into a 2-entry queue.
// ----------------------------------------------------------------------------
module gcr_front import gcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [20:0] s_codepoint,
    input  logic [7:0]  s_slot_index,
    output logic        q_valid,
    input  logic        q_ready,
    output gcr_item_t   q_item
);
    gcr_item_t  mem_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg].ch   <= fold_to_ascii(s_codepoint);
            mem_reg[wp_reg].slot <= s_slot_index;
        end
    end
endmodule

// ----- hw/rtl/gcr_back.sv -----
// ----------------------------------------------------------------------------
// gcr_back
// Walks the scaled rows of one glyph and emits a row write each cycle while m_ready allows.
// ----------------------------------------------------------------------------
module gcr_back import gcr_pkg::*; #(
    parameter int CELL_COLUMNS = 32,
    parameter int CELL_WIDTH   = 16,
    parameter int CELL_HEIGHT  = 20,
    parameter int PIXEL_SCALE  = 2,
    parameter int MAX_SLOTS    = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  gcr_item_t  q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [8:0] m_pixel_x,
    output logic [7:0] m_pixel_y,
    output logic [9:0] m_row_mask,
    output logic       m_blank_glyph,
    output logic [3:0] m_advance_px,
    output logic       m_last_row
);
    localparam int TOTAL = GLYPH_ROWS * PIXEL_SCALE;
    localparam int RW    = $clog2(TOTAL + 1);
    localparam int SW    = $clog2(PIXEL_SCALE + 1);
    localparam int XOFF  = (CELL_WIDTH - GLYPH_COLS * PIXEL_SCALE) / 2;

    glyph_t         glyph_reg;
    logic [2:0]     src_reg;
    logic [SW-1:0]  sub_reg;
    logic [RW-1:0]  r_reg;
    logic           busy_reg;
    logic [8:0]     x_reg;
    logic [7:0]     y_reg;
    logic           blank_reg;
    logic           advance;
    logic [8:0]     x_tab [256];
    logic [7:0]     y_tab [256];
    logic [4:0]     bits;
    logic [GLYPH_COLS*PIXEL_SCALE-1:0] wide_mask;
    logic [9:0]     mask;

    // Cell origin per slot, folded to a constant table.
    for (genvar i = 0; i < 256; i++) begin : g_slot_tab
        assign x_tab[i] = 9'(((i % MAX_SLOTS) % CELL_COLUMNS) * CELL_WIDTH + XOFF);
        assign y_tab[i] = 8'(((i % MAX_SLOTS) / CELL_COLUMNS) * CELL_HEIGHT + TOP_MARGIN);
    end

    assign advance = !m_valid || m_ready;
    assign q_ready = advance && (!busy_reg || (r_reg == RW'(TOTAL - 1)));
    assign bits    = glyph_reg[3'(GLYPH_ROWS - 1) - src_reg];

    always_comb begin
        wide_mask = '0;
        for (int c = 0; c < GLYPH_COLS; c++)
            for (int s = 0; s < PIXEL_SCALE; s++)
                wide_mask[(GLYPH_COLS - 1 - c) * PIXEL_SCALE + s] = bits[GLYPH_COLS - 1 - c];
    end

    assign mask = 10'(wide_mask);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            m_valid  <= 1'b0;
        end else if (advance) begin
            m_valid <= busy_reg;
            if (q_valid && q_ready) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && r_reg == RW'(TOTAL - 1)) begin
                busy_reg <= 1'b0;
            end
        end
        if (advance) begin
            if (busy_reg) begin
                m_pixel_x     <= x_reg;
                m_pixel_y     <= y_reg + 8'(r_reg);
                m_row_mask    <= mask;
                m_blank_glyph <= blank_reg;
                m_advance_px  <= blank_reg ? ADV_BLANK : ADV_NORMAL;
                m_last_row    <= (r_reg == RW'(TOTAL - 1));
            end
            if (q_valid && q_ready) begin
                glyph_reg <= font_rom(q_item.ch);
                blank_reg <= (q_item.ch == CH_SPACE);
                x_reg     <= x_tab[q_item.slot];
                y_reg     <= y_tab[q_item.slot];
                r_reg     <= '0;
                sub_reg   <= '0;
                src_reg   <= '0;
            end else if (busy_reg) begin
                r_reg <= r_reg + RW'(1);
                if (sub_reg == SW'(PIXEL_SCALE - 1)) begin
                    sub_reg <= '0;
                    src_reg <= src_reg + 3'd1;
                end else begin
                    sub_reg <= sub_reg + SW'(1);
                end
            end
        end
    end
endmodule

// ----- hw/rtl/glyph_cell_rasterizer.sv -----
// ----------------------------------------------------------------------------
// glyph_cell_rasterizer
// 5x7 font character generator writing scaled glyph rows into atlas cells.
// ----------------------------------------------------------------------------
// Each accepted codepoint yields 7*PIXEL_SCALE row words (14 by default), one
// per cycle from the row walker in the back end while m_ready stays high. The
// front end folds codepoints into a two-entry queue, so the next item is
// accepted while the current glyph drains.
module glyph_cell_rasterizer import gcr_pkg::*; #(
    parameter int CELL_COLUMNS = 32,
    parameter int CELL_WIDTH   = 16,
    parameter int CELL_HEIGHT  = 20,
    parameter int PIXEL_SCALE  = 2,
    parameter int MAX_SLOTS    = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [20:0] s_codepoint,
    input  logic [7:0]  s_slot_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_pixel_x,
    output logic [7:0]  m_pixel_y,
    output logic [9:0]  m_row_mask,
    output logic        m_blank_glyph,
    output logic [3:0]  m_advance_px,
    output logic        m_last_row
);
    logic      q_valid, q_ready;
    gcr_item_t q_item;

    gcr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_codepoint, .s_slot_index,
        .q_valid, .q_ready, .q_item
    );

    gcr_back #(
        .CELL_COLUMNS(CELL_COLUMNS), .CELL_WIDTH(CELL_WIDTH),
        .CELL_HEIGHT(CELL_HEIGHT), .PIXEL_SCALE(PIXEL_SCALE), .MAX_SLOTS(MAX_SLOTS)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item, .m_valid, .m_ready,
        .m_pixel_x, .m_pixel_y, .m_row_mask, .m_blank_glyph, .m_advance_px,
        .m_last_row
    );

    a_blank_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blank_glyph |-> m_row_mask == '0 && m_advance_px == ADV_BLANK)
        else $error("blank glyph with pixels");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_blank_glyph |-> m_advance_px == ADV_NORMAL)
        else $error("bad advance");
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row ##1 m_valid |->
        m_pixel_y == $past(m_pixel_y) + 8'd1 && m_pixel_x == $past(m_pixel_x))
        else $error("row sequence broken");
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Glyph cell rasterizer testbench
// Drives codepoint/slot words with random gaps and checks every row word the
// block emits against a glyph-folding and font predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gcr_pkg::*;

    typedef struct packed {
        logic [8:0] px;
        logic [7:0] py;
        logic [9:0] mask;
        logic       blank;
        logic [3:0] adv;
        logic       last;
    } row_word_t;

    class row_scoreboard;
        row_word_t pending_rows[$];
        int errors;

        function logic [7:0] fold(logic [20:0] cp);
            logic [7:0] r;
            r = {1'b0, CH_QMARK};
            if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) r = {1'b0, CH_QMARK};
            else if (cp < 21'h80) r = {1'b0, cp[6:0]};
            else if ((cp >= 'hC0 && cp <= 'hC6) || (cp >= 'hE0 && cp <= 'hE6)) r = "A";
            else if ((cp >= 'hC8 && cp <= 'hCB) || (cp >= 'hE8 && cp <= 'hEB)) r = "E";
            else if ((cp >= 'hCC && cp <= 'hCF) || (cp >= 'hEC && cp <= 'hEF)) r = "I";
            else if ((cp >= 'hD2 && cp <= 'hD6) || (cp >= 'hF2 && cp <= 'hF6) ||
                     cp == 'hD8 || cp == 'hF8) r = "O";
            else if ((cp >= 'hD9 && cp <= 'hDC) || (cp >= 'hF9 && cp <= 'hFC)) r = "U";
            else begin
                case (cp)
                    'hA0: r = " ";
                    'hA1: r = "!";
                    'hA9, 'hC7, 'hE7: r = "C";
                    'hAB, 'hBB, 'h201C, 'h201D: r = "\"";
                    'hB0: r = "o";
                    'hB7, 'h2026: r = ".";
                    'hD0, 'hF0: r = "D";
                    'hD1, 'hF1: r = "N";
                    'hDD, 'hFD, 'hFF: r = "Y";
                    'hDE, 'hFE: r = "P";
                    'hDF: r = "S";
                    'hD7: r = "x";
                    'hF7: r = "/";
                    'h2013, 'h2014: r = "-";
                    'h2018, 'h2019: r = "'";
                    'h2022: r = "*";
                    'h20AC: r = "E";
                    default: r = {1'b0, CH_QMARK};
                endcase
            end
            return r;
        endfunction

        function logic [34:0] glyph_bits(logic [7:0] c);
            if (c >= "a" && c <= "z") c = c - 8'd32;
            case (c)
                " ": return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
                "A": return {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
                "B": return {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
                "C": return {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
                "D": return {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
                "E": return {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
                "F": return {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
                "G": return {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E};
                "H": return {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
                "I": return {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
                "J": return {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
                "K": return {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
                "L": return {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
                "M": return {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
                "N": return {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
                "O": return {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
                "P": return {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
                "Q": return {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
                "R": return {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
                "S": return {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
                "T": return {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
                "U": return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
                "V": return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
                "W": return {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
                "X": return {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
                "Y": return {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
                "Z": return {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
                "0": return {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
                "1": return {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
                "2": return {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
                "3": return {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
                "4": return {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
                "5": return {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
                "6": return {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
                "7": return {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
                "8": return {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
                "9": return {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
                ".": return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06};
                ",": return {5'h00,5'h00,5'h00,5'h00,5'h06,5'h06,5'h04};
                ":": return {5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h00};
                ";": return {5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h04};
                "!": return {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
                "-": return {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
                "+": return {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
                "/": return {5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00};
                "\\": return {5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00};
                "(": return {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02};
                ")": return {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08};
                "[": return {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E};
                "]": return {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E};
                "{": return {5'h02,5'h04,5'h04,5'h08,5'h04,5'h04,5'h02};
                "}": return {5'h08,5'h04,5'h04,5'h02,5'h04,5'h04,5'h08};
                "_": return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F};
                "\"": return {5'h0A,5'h0A,5'h04,5'h00,5'h00,5'h00,5'h00};
                "'": return {5'h04,5'h04,5'h02,5'h00,5'h00,5'h00,5'h00};
                default: return {5'h0E,5'h11,5'h02,5'h04,5'h04,5'h00,5'h04};
            endcase
        endfunction

        function void note_glyph(logic [20:0] cp, logic [7:0] slot);
            logic [7:0] c;
            logic [34:0] bits;
            logic [4:0] src;
            row_word_t w;
            c = fold(cp);
            bits = glyph_bits(c);
            for (int r = 0; r < 14; r++) begin
                src = bits[34 - 5*(r/2) -: 5];
                for (int k = 0; k < 5; k++) begin
                    w.mask[9-2*k] = src[4-k];
                    w.mask[8-2*k] = src[4-k];
                end
                w.px = 9'(slot[4:0] * 16 + 3);
                w.py = 8'(slot[7:5] * 20 + 2 + r);
                w.blank = (c == {1'b0, CH_SPACE});
                w.adv = w.blank ? ADV_BLANK : ADV_NORMAL;
                w.last = (r == 13);
                pending_rows.insert(pending_rows.size(), w);
            end
        endfunction

        function void check_row(row_word_t got);
            row_word_t e;
            if (pending_rows.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected row word x=%0d y=%0d", got.px, got.py);
                return;
            end
            e = pending_rows.pop_front();
            if (got != e) begin
                errors++;
                if (errors <= 10)
                    $display({"row mismatch: exp x=%0d y=%0d m=%h b=%0d a=%0d l=%0d",
                              "  got x=%0d y=%0d m=%h b=%0d a=%0d l=%0d"},
                             e.px, e.py, e.mask, e.blank, e.adv, e.last,
                             got.px, got.py, got.mask, got.blank, got.adv, got.last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [20:0] s_codepoint = 0;
    logic [7:0]  s_slot_index = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [8:0]  m_pixel_x;
    logic [7:0]  m_pixel_y;
    logic [9:0]  m_row_mask;
    logic        m_blank_glyph;
    logic [3:0]  m_advance_px;
    logic        m_last_row;

    row_scoreboard sb = new();
    bit hold_sink = 0;
    longint cycles = 0;

    glyph_cell_rasterizer dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Monitor checks each accepted row word; the sink below stalls at random plus one long forced hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_row('{m_pixel_x, m_pixel_y, m_row_mask, m_blank_glyph,
                           m_advance_px, m_last_row});
    end

    initial begin
        int g;
        @(posedge aclk);
        while (1) begin
            if (hold_sink) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_ready <= (g == 0);
            @(posedge aclk);
            if (g > 0) begin
                repeat (g - 1) @(posedge aclk);
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_glyph(logic [20:0] cp, logic [7:0] slot, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_codepoint <= cp;
        s_slot_index <= slot;
        do @(posedge aclk); while (!s_ready);
        sb.note_glyph(cp, slot);
    endtask

    task automatic idle_until_drained();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending_rows.size() != 0) @(posedge aclk);
    endtask

    function logic [20:0] rand_codepoint();
        case ($urandom_range(0, 7))
            0, 1: return 21'($urandom_range(0, 127));
            2: return 21'($urandom_range('h80, 'hFF));
            3: return 21'($urandom_range('h2010, 'h20AF));
            4: return 21'($urandom_range('hD7F0, 'hE00F));
            5: return 21'($urandom_range('h10FFF0, 'h11000F));
            default: return 21'($urandom);
        endcase
    endfunction

    initial begin
        logic [20:0] directed_cps[] = '{21'h41, 21'h7A, 21'h20, 21'hA0, 21'h00, 21'h2A,
                                        21'h23, 21'hE9, 21'hD7, 21'hB0, 21'h2022,
                                        21'h20AC, 21'h2026, 21'h201C, 21'hD800,
                                        21'hDFFF, 21'h10FFFF, 21'h110000, 21'h1FFFFF,
                                        21'h7F, 21'hFF, 21'h100, 21'h39};
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed_cps[i])
            send_glyph(directed_cps[i], (i % 2) ? 8'hFF : 8'(i * 37), 0);
        idle_until_drained();
        // Force backpressure: sink holds off while source keeps offering.
        hold_sink = 1;
        for (int i = 0; i < 10; i++) send_glyph(rand_codepoint(), 8'($urandom), 1);
        idle_until_drained();
        for (int i = 0; i < 340; i++) begin
            send_glyph(rand_codepoint(), 8'($urandom), ($urandom_range(0, 4) == 0));
            if (i == 170) idle_until_drained();
        end
        idle_until_drained();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_rows.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
